>>> hdl/record_sort_by_score_sum_defines.svh
// Assertion macros used by the record sort sequencer, rsss_ctrl.
// Expects clk and rst in scope at the point of use; no other dependencies.
`ifndef RECORD_SORT_BY_SCORE_SUM_DEFINES_SVH
`define RECORD_SORT_BY_SCORE_SUM_DEFINES_SVH

// Condition that must hold at every clock edge outside reset.
`define RSSS_ASSERT_HOLDS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("rsss: invariant violated");

// Same-cycle implication.
`define RSSS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rsss: implication violated");

// Next-cycle implication.
`define RSSS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rsss: next-cycle check violated");

`endif

>>> hdl/rsss_pkg.sv
// Package for the record sort: sizes, record and control types, key function.
// No dependencies.
`default_nettype none

package rsss_pkg;

  localparam int RECORDS     = 8;
  localparam int SCORE_BITS  = 10;
  localparam int ID_W        = 32;
  localparam int IDX_W       = (RECORDS > 1) ? $clog2(RECORDS) : 1;
  localparam int CNT_W       = $clog2(RECORDS + 1);
  localparam int KEY_W       = SCORE_BITS + 2;
  localparam int IN_BITS     = ID_W + 3 * SCORE_BITS;
  localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS    = IN_BITS + IDX_W;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  typedef logic [SCORE_BITS-1:0] score_t;
  typedef logic [KEY_W-1:0]      key_t;

  // Packed so that the lowest bits hold the identifier, as on the stream.
  typedef struct packed {
    logic [IDX_W-1:0] slot;
    score_t           score_c;
    score_t           score_b;
    score_t           score_a;
    logic [ID_W-1:0]  id;
  } rec_t;

  typedef enum logic {
    ST_LOAD,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic             insert;
    logic             shift;
    logic [IDX_W-1:0] slot;
  } chain_ctrl_t;

  function automatic key_t key_of(rec_t r);
    key_of = key_t'(r.score_a) + key_t'(r.score_b) + key_t'(r.score_c);
  endfunction

endpackage

`default_nettype wire

>>> hdl/rsss_cell.sv
// One cell of the sorted insertion chain: holds one record and its key.
// Depends on rsss_pkg.
`default_nettype none

module rsss_cell (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire rsss_pkg::chain_ctrl_t ctrl,
  input  wire rsss_pkg::rec_t       new_rec,
  input  wire rsss_pkg::key_t       new_key,
  input  wire logic                 prev_valid,
  input  wire logic                 prev_ins,
  input  wire rsss_pkg::rec_t       prev_rec,
  input  wire rsss_pkg::key_t       prev_key,
  input  wire logic                 next_valid,
  input  wire rsss_pkg::rec_t       next_rec,
  input  wire rsss_pkg::key_t       next_key,
  output logic                      valid,
  output rsss_pkg::rec_t            rec,
  output rsss_pkg::key_t            key,
  output logic                      ins
);

  // Yield the place when empty or when the new key is strictly greater;
  // equal keys stay ahead, which keeps arrival order.
  assign ins = !(valid && (key >= new_key));

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.shift) begin
      valid <= next_valid;
    end else if (ctrl.insert && ins) begin
      valid <= prev_ins ? prev_valid : 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      rec <= next_rec;
      key <= next_key;
    end else if (ctrl.insert && ins) begin
      if (prev_ins) begin
        rec <= prev_rec;
        key <= prev_key;
      end else begin
        rec <= new_rec;
        key <= new_key;
      end
    end
  end

endmodule

`default_nettype wire

>>> hdl/rsss_ctrl.sv
// Load/drain sequencer and output register for the record sort.
// Depends on rsss_pkg and record_sort_by_score_sum_defines.svh.
`default_nettype none

`include "record_sort_by_score_sum_defines.svh"

module rsss_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  input  wire logic                  in_last,
  output logic                       in_ready,
  input  wire rsss_pkg::rec_t        head_rec,
  output rsss_pkg::chain_ctrl_t      ctrl,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output rsss_pkg::rec_t             out_rec,
  output logic                       out_ovf,
  output logic                       out_last
);

  rsss_pkg::state_t           state, state_next;
  logic [rsss_pkg::CNT_W-1:0] count, count_next;
  logic                       dropped, dropped_next;
  logic                       accept;
  logic                       room;
  logic                       advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= rsss_pkg::ST_LOAD;
      count   <= '0;
      dropped <= 1'b0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      dropped <= dropped_next;
    end
  end

  always_comb begin
    in_ready     = (state == rsss_pkg::ST_LOAD);
    accept       = in_valid && in_ready;
    room         = (count < rsss_pkg::CNT_W'(rsss_pkg::RECORDS));
    advance      = (state == rsss_pkg::ST_DRAIN) && (!out_valid || out_ready);
    ctrl.insert  = accept && room;
    ctrl.shift   = advance;
    ctrl.slot    = count[rsss_pkg::IDX_W-1:0];
    state_next   = state;
    count_next   = count;
    dropped_next = dropped;
    case (state)
      rsss_pkg::ST_LOAD: begin
        if (accept) begin
          if (room) begin
            count_next = count + rsss_pkg::CNT_W'(1);
          end else begin
            dropped_next = 1'b1;
          end
          if (in_last) begin
            state_next = rsss_pkg::ST_DRAIN;
          end
        end
      end
      rsss_pkg::ST_DRAIN: begin
        if (advance) begin
          count_next = count - rsss_pkg::CNT_W'(1);
          if (count == rsss_pkg::CNT_W'(1)) begin
            state_next   = rsss_pkg::ST_LOAD;
            dropped_next = 1'b0;
          end
        end
      end
      default: begin
        state_next = rsss_pkg::ST_LOAD;
      end
    endcase
  end

  // Output register: the head of the chain moves here on each drain step.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_rec  <= head_rec;
      out_ovf  <= dropped;
      out_last <= (count == rsss_pkg::CNT_W'(1));
    end
  end

  `RSSS_ASSERT_HOLDS(a_count_bound, count <= rsss_pkg::CNT_W'(rsss_pkg::RECORDS))
  `RSSS_ASSERT_IMPL(a_no_insert_on_shift, ctrl.insert, !ctrl.shift)
  `RSSS_ASSERT_IMPL(a_drain_nonempty, state == rsss_pkg::ST_DRAIN, count != '0)
  `RSSS_ASSERT_NEXT(a_last_beat_resets, advance && (count == rsss_pkg::CNT_W'(1)),
    (state == rsss_pkg::ST_LOAD) && (count == '0) && !dropped && out_valid && out_last)

endmodule

`default_nettype wire

>>> hdl/record_sort_by_score_sum.sv
// Record sort by score sum, top level: a chain of rsss_cell and the rsss_ctrl sequencer.
// Depends on rsss_pkg, rsss_cell and rsss_ctrl.
//
// Loads a set of records (identifier plus three scores) one beat per cycle into a
// chain of RECORDS cells that stays sorted by descending score sum; each new record
// is broadcast to every cell, lands after all stored records whose sum is greater or
// equal, and the cells behind it move down one place, so equal sums keep arrival
// order. The beat with tlast set closes the set: the block then stops taking input
// and shifts the chain out through its output register, one record per cycle while
// the sink is ready, from the highest sum down, with tlast on the final record and
// tuser flagging a set in which records beyond RECORDS were dropped. Load and drain
// do not overlap: no new set is taken until the last record has left the chain
// through the single head cell. A beat arriving with the chain full is dropped but
// still closes the set when it carries tlast. arrival_index gives each record's
// load position within its set.
`default_nettype none

module record_sort_by_score_sum (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // record_id, score_a, score_b, score_c (lowest bits first), zero padded
  input  wire logic [rsss_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // set_end
  input  wire logic                             s_axis_tlast,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // out_id, out_score_a, out_score_b, out_score_c, arrival_index, zero padded
  output logic [rsss_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
  // overflow
  output logic                                  m_axis_tuser,
  // final_result
  output logic                                  m_axis_tlast
);

  localparam int SA_LO = rsss_pkg::ID_W;
  localparam int SB_LO = SA_LO + rsss_pkg::SCORE_BITS;
  localparam int SC_LO = SB_LO + rsss_pkg::SCORE_BITS;

  rsss_pkg::chain_ctrl_t ctrl;
  rsss_pkg::rec_t        new_rec;
  rsss_pkg::key_t        new_key;
  rsss_pkg::rec_t        out_rec;

  logic                  cell_valid [rsss_pkg::RECORDS];
  logic                  cell_ins   [rsss_pkg::RECORDS];
  rsss_pkg::rec_t        cell_rec   [rsss_pkg::RECORDS];
  rsss_pkg::key_t        cell_key   [rsss_pkg::RECORDS];

  // Unpack the incoming beat; the slot is the record's load position.
  always_comb begin
    new_rec.id      = s_axis_tdata[rsss_pkg::ID_W-1:0];
    new_rec.score_a = s_axis_tdata[SA_LO +: rsss_pkg::SCORE_BITS];
    new_rec.score_b = s_axis_tdata[SB_LO +: rsss_pkg::SCORE_BITS];
    new_rec.score_c = s_axis_tdata[SC_LO +: rsss_pkg::SCORE_BITS];
    new_rec.slot    = ctrl.slot;
    new_key         = rsss_pkg::key_of(new_rec);
  end

  // Cells take the new or previous record on insert, the next cell's on drain.
  for (genvar i = 0; i < rsss_pkg::RECORDS; i++) begin : g_cell
    logic           prev_valid, prev_ins, next_valid;
    rsss_pkg::rec_t prev_rec, next_rec;
    rsss_pkg::key_t prev_key, next_key;

    if (i == 0) begin : g_head
      assign prev_valid = 1'b0;
      assign prev_ins   = 1'b0;
      assign prev_rec   = '0;
      assign prev_key   = '0;
    end else begin : g_body
      assign prev_valid = cell_valid[i-1];
      assign prev_ins   = cell_ins[i-1];
      assign prev_rec   = cell_rec[i-1];
      assign prev_key   = cell_key[i-1];
    end

    if (i == rsss_pkg::RECORDS - 1) begin : g_tail
      assign next_valid = 1'b0;
      assign next_rec   = '0;
      assign next_key   = '0;
    end else begin : g_mid
      assign next_valid = cell_valid[i+1];
      assign next_rec   = cell_rec[i+1];
      assign next_key   = cell_key[i+1];
    end

    rsss_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .new_rec    (new_rec),
      .new_key    (new_key),
      .prev_valid (prev_valid),
      .prev_ins   (prev_ins),
      .prev_rec   (prev_rec),
      .prev_key   (prev_key),
      .next_valid (next_valid),
      .next_rec   (next_rec),
      .next_key   (next_key),
      .valid      (cell_valid[i]),
      .rec        (cell_rec[i]),
      .key        (cell_key[i]),
      .ins        (cell_ins[i])
    );
  end

  // Sequence load and drain; hold each drained record in the output register.
  rsss_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_last   (s_axis_tlast),
    .in_ready  (s_axis_tready),
    .head_rec  (cell_rec[0]),
    .ctrl      (ctrl),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_rec   (out_rec),
    .out_ovf   (m_axis_tuser),
    .out_last  (m_axis_tlast)
  );

  // rec_t is laid out lowest field first, matching the stream layout.
  assign m_axis_tdata = rsss_pkg::OUT_TDATA_W'(out_rec);

endmodule

`default_nettype wire

>>> test/tb_top.sv
// Testbench for record_sort_by_score_sum: streams sets of score records and checks
// every ranked record against a stable descending score-sum predictor or typed row.
// Depends on rsss_pkg and the record_sort_by_score_sum RTL.
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rsss_pkg::*;

  localparam int STIM_TARGET = 380;   // rough number of input beats
  localparam int QUIET_TAIL  = 40;    // last beats sent with no idling on either side
  localparam int CYCLE_LIMIT = 100000;

  // One input beat as the sender sees it.
  typedef struct packed {
    logic [ID_W-1:0] id;
    score_t          a;
    score_t          b;
    score_t          c;
    logic            last;
  } score_rec_t;

  // One ranked record as it leaves the block.
  typedef struct packed {
    logic [ID_W-1:0]  id;
    score_t           a;
    score_t           b;
    score_t           c;
    logic [IDX_W-1:0] idx;
    logic             ovf;
    logic             fin;
  } ranked_t;

  // A stimulus row; typed rows carry their one ranked record written out by hand.
  typedef struct {
    score_rec_t item;
    bit         typed;
    ranked_t    want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   s_axis_tlast  = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tuser;
  logic                   m_axis_tlast;

  record_sort_by_score_sum dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor: a rank list of the records held in the current set.
  // ---------------------------------------------------------------------------
  logic [ID_W-1:0]  held_id    [RECORDS];
  score_t           held_a     [RECORDS];
  score_t           held_b     [RECORDS];
  score_t           held_c     [RECORDS];
  key_t             held_key   [RECORDS];
  logic [IDX_W-1:0] held_order [RECORDS];   // slots, highest sum first
  int               held_n  = 0;
  bit               spilled = 1'b0;

  ranked_t   ranked_q [$];   // ranked records still owed by the block
  stim_row_t stim_q   [$];
  stim_row_t directed_rows [18];

  int beats_in   = 0;
  int mismatches = 0;
  int cycle_n    = 0;

  // Insert one accepted beat into the rank list; on the closing beat queue the
  // whole set in rank order (unless the row brings its own typed result) and clear.
  task automatic rank_record(input score_rec_t r, input bit emit);
    int      pos;
    key_t    k;
    ranked_t res;
    if (held_n < RECORDS) begin
      held_id[held_n] = r.id;
      held_a[held_n]  = r.a;
      held_b[held_n]  = r.b;
      held_c[held_n]  = r.c;
      k = key_t'(r.a) + key_t'(r.b) + key_t'(r.c);
      held_key[held_n] = k;
      // land behind every held record whose sum is greater or equal
      pos = 0;
      while (pos < held_n && held_key[held_order[pos]] >= k) pos++;
      for (int i = held_n; i > pos; i--) held_order[i] = held_order[i-1];
      held_order[pos] = IDX_W'(held_n);
      held_n++;
    end else begin
      spilled = 1'b1;   // store full: drop the record, remember it for the set
    end
    if (r.last) begin
      if (emit) begin
        for (int i = 0; i < held_n; i++) begin
          res.id  = held_id[held_order[i]];
          res.a   = held_a[held_order[i]];
          res.b   = held_b[held_order[i]];
          res.c   = held_c[held_order[i]];
          res.idx = held_order[i];
          res.ovf = spilled;
          res.fin = (i == held_n - 1);
          ranked_q.push_back(res);
        end
      end
      held_n  = 0;
      spilled = 1'b0;
    end
  endtask

  task automatic check_field(input string name, input logic [ID_W-1:0] want,
                             input logic [ID_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  // Mostly in range, often from a small pool so that sums tie, now and then
  // above 1000, which the block keeps as given.
  function automatic score_t pick_score();
    int sel;
    sel = $urandom_range(0, 11);
    if (sel < 4) begin
      case ($urandom_range(0, 3))
        0: return score_t'(0);
        1: return score_t'(100);
        2: return score_t'(500);
        default: return score_t'(1000);
      endcase
    end else if (sel == 11) begin
      return score_t'($urandom_range(1001, 1023));
    end
    return score_t'($urandom_range(0, 1000));
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus: directed rows, then random sets.
  // ---------------------------------------------------------------------------
  initial begin : build_stimulus
    int        set_len;
    stim_row_t row;
    directed_rows = '{
      // single-record sets: the record comes straight back, ranked first and last
      '{'{32'h0000_0000, 10'd0, 10'd0, 10'd0, 1'b1}, 1'b1,
        '{32'h0000_0000, 10'd0, 10'd0, 10'd0, 3'd0, 1'b0, 1'b1}},
      '{'{32'hFFFF_FFFF, 10'd1000, 10'd1000, 10'd1000, 1'b1}, 1'b1,
        '{32'hFFFF_FFFF, 10'd1000, 10'd1000, 10'd1000, 3'd0, 1'b0, 1'b1}},
      // scores above 1000 pass through untouched
      '{'{32'h5A5A_A5A5, 10'd1023, 10'd1023, 10'd1023, 1'b1}, 1'b1,
        '{32'h5A5A_A5A5, 10'd1023, 10'd1023, 10'd1023, 3'd0, 1'b0, 1'b1}},
      // equal sums from different scores: arrival order must hold
      '{'{32'd10, 10'd100, 10'd200, 10'd300, 1'b0}, 1'b0, '0},
      '{'{32'd11, 10'd300, 10'd200, 10'd100, 1'b0}, 1'b0, '0},
      '{'{32'd12, 10'd600, 10'd0,   10'd0,   1'b1}, 1'b0, '0},
      // rising then falling sums
      '{'{32'd20, 10'd1,   10'd0,    10'd0,    1'b0}, 1'b0, '0},
      '{'{32'd21, 10'd999, 10'd1000, 10'd1000, 1'b0}, 1'b0, '0},
      '{'{32'd22, 10'd500, 10'd500,  10'd0,    1'b1}, 1'b0, '0},
      // store overflow: the ninth record is dropped but still closes the set
      '{'{32'd30, 10'd10,  10'd20,  10'd30,  1'b0}, 1'b0, '0},
      '{'{32'd31, 10'd900, 10'd0,   10'd0,   1'b0}, 1'b0, '0},
      '{'{32'd32, 10'd0,   10'd0,   10'd0,   1'b0}, 1'b0, '0},
      '{'{32'd33, 10'd300, 10'd300, 10'd300, 1'b0}, 1'b0, '0},
      '{'{32'd34, 10'd60,  10'd0,   10'd0,   1'b0}, 1'b0, '0},
      '{'{32'd35, 10'd1000,10'd1000,10'd1000,1'b0}, 1'b0, '0},
      '{'{32'd36, 10'd450, 10'd450, 10'd0,   1'b0}, 1'b0, '0},
      '{'{32'd37, 10'd512, 10'd256, 10'd128, 1'b0}, 1'b0, '0},
      '{'{32'd38, 10'd777, 10'd777, 10'd777, 1'b1}, 1'b0, '0}
    };
    foreach (directed_rows[i]) stim_q.push_back(directed_rows[i]);

    // random sets, mostly within capacity, about one in ten overflowing
    while (stim_q.size() < STIM_TARGET) begin
      set_len = ($urandom_range(0, 9) == 0) ? $urandom_range(RECORDS + 1, RECORDS + 3)
                                            : $urandom_range(1, RECORDS);
      for (int i = 0; i < set_len; i++) begin
        row.item.id   = $urandom;
        row.item.a    = pick_score();
        row.item.b    = pick_score();
        row.item.c    = pick_score();
        row.item.last = (i == set_len - 1);
        row.typed     = 1'b0;
        row.want      = '0;
        stim_q.push_back(row);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Drive both sides and check, all in one process on the rising edge, so that
  // the order of events inside a time step never matters.
  // ---------------------------------------------------------------------------
  int        next_row  = 0;
  int        send_gap  = 0;
  int        recv_gap  = 0;
  stim_row_t in_flight;

  always @(posedge clk) begin : drive_and_check
    logic    nv;
    logic    nr;
    bit      quiet;
    ranked_t want;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      m_axis_tready <= 1'b0;
    end else begin
      quiet = (next_row >= stim_q.size() - QUIET_TAIL);

      // input beat taken: update the predictor before any result can show up
      if (s_axis_tvalid && s_axis_tready) begin
        rank_record(in_flight.item, !in_flight.typed);
        if (in_flight.typed) ranked_q.push_back(in_flight.want);
        beats_in++;
      end

      // output beat taken: compare with the oldest owed record
      if (m_axis_tvalid && m_axis_tready) begin
        if (ranked_q.size() == 0) begin
          $error("unexpected output beat, id %0h", m_axis_tdata[ID_W-1:0]);
          mismatches++;
        end else begin
          want = ranked_q.pop_front();
          check_field("out_id", want.id, m_axis_tdata[ID_W-1:0]);
          check_field("out_score_a", ID_W'(want.a),
                      ID_W'(m_axis_tdata[ID_W +: SCORE_BITS]));
          check_field("out_score_b", ID_W'(want.b),
                      ID_W'(m_axis_tdata[ID_W + SCORE_BITS +: SCORE_BITS]));
          check_field("out_score_c", ID_W'(want.c),
                      ID_W'(m_axis_tdata[ID_W + 2*SCORE_BITS +: SCORE_BITS]));
          check_field("arrival_index", ID_W'(want.idx),
                      ID_W'(m_axis_tdata[IN_BITS +: IDX_W]));
          check_field("overflow", ID_W'(want.ovf), ID_W'(m_axis_tuser));
          check_field("final_result", ID_W'(want.fin), ID_W'(m_axis_tlast));
        end
      end

      // sender: hold a beat until taken, otherwise idle in bursts or offer the next
      if (!(s_axis_tvalid && !s_axis_tready)) begin
        nv = 1'b0;
        if (send_gap > 0) begin
          send_gap--;
        end else if (next_row < stim_q.size()) begin
          if (!quiet && $urandom_range(0, 7) == 0) begin
            send_gap = $urandom_range(1, 9) - 1;
          end else begin
            in_flight = stim_q[next_row];
            next_row++;
            nv = 1'b1;
            s_axis_tdata <= IN_TDATA_W'({in_flight.item.c, in_flight.item.b,
                                         in_flight.item.a, in_flight.item.id});
            s_axis_tlast <= in_flight.item.last;
          end
        end
        s_axis_tvalid <= nv;
      end

      // receiver: stall in bursts, never once the tail of the run is reached
      if (recv_gap > 0) begin
        recv_gap--;
        nr = 1'b0;
      end else if (!quiet && $urandom_range(0, 6) == 0) begin
        recv_gap = $urandom_range(1, 9) - 1;
        nr = 1'b0;
      end else begin
        nr = 1'b1;
      end
      m_axis_tready <= nr;
    end
  end

  // Hold reset at the start, then run to the end of the stimulus and drain.
  initial begin : run_control
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    while (beats_in < stim_q.size()) @(posedge clk);
    while (ranked_q.size() != 0) @(posedge clk);
    // allow a stray extra beat to surface before the verdict
    repeat (2 * RECORDS + 10) @(posedge clk);
    if (mismatches == 0) begin
      $display("record_sort_by_score_sum: match");
    end else begin
      $display("record_sort_by_score_sum: mismatch");
    end
    $finish;
  end

  // Watchdog: a hung handshake or a missing record ends the run here.
  always @(posedge clk) begin
    cycle_n <= cycle_n + 1;
    if (cycle_n == CYCLE_LIMIT) begin
      $display("record_sort_by_score_sum: mismatch");
      $finish;
    end
  end

endmodule

`default_nettype wire
